>>> rtl/hsl2rgb_pkg.sv
`timescale 1ns / 1ps
package hsl2rgb_pkg;

  localparam int unsigned HueFull    = 360;
  localparam int unsigned HueThird   = 120;
  localparam int unsigned HueSeg     = 60;
  localparam int unsigned HueFlat    = 180;
  localparam int unsigned HueEnd     = 240;
  localparam int unsigned PctMax     = 100;
  localparam int unsigned PctHalf    = 50;
  localparam int unsigned LevelTwice = 200;

  // floor(2^24 / 360), quotient estimate is low by at most one
  localparam int unsigned HueRecip  = 46603;
  localparam int unsigned HueShift  = 24;

  // 255 / 600000 reduces to 17 / 40000
  localparam int unsigned ScaleNum   = 17;
  localparam int unsigned ScaleDen   = 40000;
  // floor(17 * 2^32 / 40000), quotient estimate is low by at most one
  localparam int unsigned ScaleRecip = 1825361;
  localparam int unsigned ScaleShift = 32;

  localparam int unsigned NumChan = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  typedef struct packed {
    logic [15:0] hue_degrees;
    logic [7:0]  saturation_percent;
    logic [7:0]  lightness_percent;
  } hsl2rgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsl2rgb_out_t;

  // low level, ramp span and per-channel ramp weight (0..60)
  typedef struct packed {
    logic [13:0]                  lo;
    logic [13:0]                  diff;
    logic [NumChan-1:0][5:0]      fac;
  } hsl2rgb_lvl_t;

  // ramp(t) = lo*60 + diff*weight(t)
  function automatic logic [5:0] ramp_weight(input logic [8:0] t);
    logic [8:0] down;
    logic [5:0] w;
    down = 9'(HueEnd) - t;
    if (t < 9'(HueSeg)) begin
      w = t[5:0];
    end else if (t < 9'(HueFlat)) begin
      w = 6'(HueSeg);
    end else if (t < 9'(HueEnd)) begin
      w = down[5:0];
    end else begin
      w = 6'd0;
    end
    return w;
  endfunction

endpackage

>>> rtl/hsl_to_rgb_integer_unit.sv
`timescale 1ns / 1ps
// a beat taken at a clock edge goes through every stage and then shows on
// out_data with out_valid for one cycle. throughput: one beat per clock,
// set by the six-stage pipeline that accepts every cycle; busy is high only
// in reset. reset (rst_n low, synchronous) clears all stage valid bits, so
// no result follows a beat in flight at reset. out_valid cannot be held off.
module hsl_to_rgb_integer_unit import hsl2rgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  hsl2rgb_in_t  in_data,
  output logic         out_valid,
  output hsl2rgb_out_t out_data
);

  logic         accept;
  logic         lvl_valid;
  hsl2rgb_lvl_t lvl_data;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // zero saturation needs no path of its own: lo == hi gives l*255/100
  hsl2rgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .lvl_valid (lvl_valid),
    .lvl_data  (lvl_data)
  );

  hsl2rgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lvl_valid (lvl_valid),
    .lvl_data  (lvl_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 6))
    else $error("result without an accepted beat");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && in_data.saturation_percent == 8'd0, 6))
      |-> (out_data.red == out_data.green && out_data.green == out_data.blue))
    else $error("zero saturation gave unequal channels");

endmodule

>>> rtl/hsl2rgb_front.sv
`timescale 1ns / 1ps
module hsl2rgb_front import hsl2rgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  hsl2rgb_in_t  in_data,
  output logic         lvl_valid,
  output hsl2rgb_lvl_t lvl_data
);

  // stage 1: hue quotient estimate, clamping
  logic        v1_r;
  logic [15:0] h1_r;
  logic [7:0]  q1_r, q1_nxt;
  logic [6:0]  s1_r, s1_nxt, l1_r, l1_nxt;
  logic [31:0] hue_prod;

  assign hue_prod = 32'(in_data.hue_degrees) * 32'(HueRecip);
  assign q1_nxt   = hue_prod[HueShift +: 8];
  assign s1_nxt   = (in_data.saturation_percent > 8'(PctMax)) ? 7'(PctMax)
                                                               : in_data.saturation_percent[6:0];
  assign l1_nxt   = (in_data.lightness_percent > 8'(PctMax)) ? 7'(PctMax)
                                                              : in_data.lightness_percent[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    h1_r <= in_data.hue_degrees;
    q1_r <= q1_nxt;
    s1_r <= s1_nxt;
    l1_r <= l1_nxt;
  end

  // stage 2: hue remainder with one correction, high level
  logic        v2_r;
  logic [8:0]  hm2_r, hm2_nxt;
  logic [13:0] hi2_r, hi2_nxt;
  logic [6:0]  l2_r;
  logic [15:0] hue_rem;
  logic [9:0]  rem10;
  logic [14:0] ls_prod, hi_dark, hi_bright;

  assign hue_rem = h1_r - 16'(q1_r) * 16'(HueFull);
  assign rem10   = hue_rem[9:0];
  assign hm2_nxt = (rem10 >= 10'(HueFull)) ? 9'(rem10 - 10'(HueFull)) : rem10[8:0];

  assign ls_prod   = 15'(s1_r) * 15'(l1_r);
  assign hi_dark   = 15'(l1_r) * (15'(PctMax) + 15'(s1_r));
  assign hi_bright = (15'(l1_r) + 15'(s1_r)) * 15'(PctMax) - ls_prod;
  assign hi2_nxt   = (l1_r < 7'(PctHalf)) ? hi_dark[13:0] : hi_bright[13:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    hm2_r <= hm2_nxt;
    hi2_r <= hi2_nxt;
    l2_r  <= l1_r;
  end

  // stage 3: low level, span, channel hue angles to ramp weights
  logic         v3_r;
  hsl2rgb_lvl_t lvl_r, lvl_nxt;
  logic [14:0]  lo_full;
  logic [8:0]   ang_red, ang_blue;

  assign lo_full  = 15'(l2_r) * 15'(LevelTwice) - 15'(hi2_r);
  assign ang_red  = (hm2_r < 9'(HueEnd)) ? hm2_r + 9'(HueThird) : hm2_r - 9'(HueEnd);
  assign ang_blue = (hm2_r >= 9'(HueThird)) ? hm2_r - 9'(HueThird) : hm2_r + 9'(HueEnd);

  always_comb begin
    lvl_nxt              = '0;
    lvl_nxt.lo           = lo_full[13:0];
    lvl_nxt.diff         = hi2_r - lo_full[13:0];
    lvl_nxt.fac[ChRed]   = ramp_weight(ang_red);
    lvl_nxt.fac[ChGreen] = ramp_weight(hm2_r);
    lvl_nxt.fac[ChBlue]  = ramp_weight(ang_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
  end

  assign lvl_valid = v3_r;
  assign lvl_data  = lvl_r;

endmodule

>>> rtl/hsl2rgb_scale.sv
`timescale 1ns / 1ps
module hsl2rgb_scale import hsl2rgb_pkg::*; (
  input  logic        clk,
  input  logic [19:0] ramp,
  output logic [7:0]  chan
);

  // ramp * 17 / 40000 via reciprocal, then one correction step
  logic [19:0] ramp5_r;
  logic [8:0]  q5_r;
  logic [40:0] scale_prod;

  assign scale_prod = 41'(ramp) * 41'(ScaleRecip);

  always_ff @(posedge clk) begin
    ramp5_r <= ramp;
    q5_r    <= scale_prod[ScaleShift +: 9];
  end

  logic [7:0]  chan_r, chan_nxt;
  logic [23:0] num, rem;

  assign num      = 24'(ramp5_r) * 24'(ScaleNum);
  assign rem      = num - 24'(q5_r) * 24'(ScaleDen);
  assign chan_nxt = (rem >= 24'(ScaleDen)) ? 8'(q5_r + 9'd1) : q5_r[7:0];

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

>>> rtl/hsl2rgb_back.sv
`timescale 1ns / 1ps
module hsl2rgb_back import hsl2rgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         lvl_valid,
  input  hsl2rgb_lvl_t lvl_data,
  output logic         out_valid,
  output hsl2rgb_out_t out_data
);

  // stage 4: ramp value per channel, at most 600000
  logic        v4_r, v5_r, v6_r;
  logic [19:0] ramp4_r [NumChan];
  logic [7:0]  chan    [NumChan];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumChan; i++) begin
      ramp4_r[i] <= 20'(lvl_data.lo) * 20'(HueSeg) + 20'(lvl_data.diff) * 20'(lvl_data.fac[i]);
    end
  end

  // stages 5 and 6 live in the scale lanes
  for (genvar g = 0; g < NumChan; g++) begin : g_lane
    hsl2rgb_scale u_scale (
      .clk  (clk),
      .ramp (ramp4_r[g]),
      .chan (chan[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= lvl_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign out_valid      = v6_r;
  assign out_data.red   = chan[ChRed];
  assign out_data.green = chan[ChGreen];
  assign out_data.blue  = chan[ChBlue];

endmodule

>>> sim/hsl_to_rgb_checker.sv
`timescale 1ns / 1ps
module hsl_to_rgb_checker import hsl2rgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  hsl2rgb_in_t  in_data,
  input  logic         out_valid,
  input  hsl2rgb_out_t out_data,
  output int           mismatches,
  output int           outstanding
);

  hsl2rgb_out_t expected_rgb[$];

  // level along one hue ramp, scaled by 100*100*60
  function automatic int unsigned hue_ramp_level(int unsigned lo, int unsigned hi,
                                                 int unsigned t);
    if (t < HueSeg) begin
      return lo * HueSeg + (hi - lo) * t;
    end
    if (t < HueFlat) begin
      return hi * HueSeg;
    end
    if (t < HueEnd) begin
      return lo * HueSeg + (hi - lo) * (HueEnd - t);
    end
    return lo * HueSeg;
  endfunction

  function automatic hsl2rgb_out_t convert_hsl(hsl2rgb_in_t c);
    int unsigned h, s, l, hi, lo, grey, t_red, t_blue;
    hsl2rgb_out_t rgb;
    h = c.hue_degrees % HueFull;
    s = (c.saturation_percent > PctMax) ? PctMax : c.saturation_percent;
    l = (c.lightness_percent > PctMax) ? PctMax : c.lightness_percent;
    if (s == 0) begin
      grey = l * 255 / PctMax;
      rgb.red   = grey[7:0];
      rgb.green = grey[7:0];
      rgb.blue  = grey[7:0];
    end else begin
      if (l < PctHalf) begin
        hi = l * (PctMax + s);
      end else begin
        hi = (l + s) * PctMax - s * l;
      end
      lo = l * LevelTwice - hi;
      t_red  = (h < HueEnd) ? h + HueThird : h - HueEnd;
      t_blue = (h >= HueThird) ? h - HueThird : h + HueEnd;
      rgb.red   = 8'(hue_ramp_level(lo, hi, t_red) * 255 / 600000);
      rgb.green = 8'(hue_ramp_level(lo, hi, h) * 255 / 600000);
      rgb.blue  = 8'(hue_ramp_level(lo, hi, t_blue) * 255 / 600000);
    end
    return rgb;
  endfunction

  always @(posedge clk) begin
    hsl2rgb_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_rgb.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected rgb beat r=%0d g=%0d b=%0d", $realtime,
                     out_data.red, out_data.green, out_data.blue);
          end
          mismatches = mismatches + 1;
        end else begin
          want = expected_rgb.pop_front();
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue) begin
            if (mismatches < 10) begin
              $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       out_data.red, out_data.green, out_data.blue);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_rgb.push_back(convert_hsl(in_data));
      end
    end
    outstanding = expected_rgb.size();
  end

endmodule

>>> sim/tb_hsl_to_rgb_integer_unit.sv
`timescale 1ns / 1ps
module tb_hsl_to_rgb_integer_unit import hsl2rgb_pkg::*;;

  localparam int NumItems   = 1850;
  localparam int CycleLimit = 400000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         start;
  logic         busy;
  hsl2rgb_in_t  in_data;
  logic         out_valid;
  hsl2rgb_out_t out_data;
  int           mismatches;
  int           outstanding;
  int           cycles;
  bit           quiet_burst;

  hsl_to_rgb_integer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  hsl_to_rgb_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(bit no_gaps);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // ramp corners and hue wrap points
  function automatic logic [15:0] edge_hue();
    int unsigned corner[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
    return 16'(corner[$urandom_range(0, 11)] + 360 * $urandom_range(0, 181));
  endfunction

  function automatic hsl2rgb_in_t random_color();
    hsl2rgb_in_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.hue_degrees        = 16'($urandom_range(0, 359));
    c.saturation_percent = 8'($urandom_range(0, 100));
    c.lightness_percent  = 8'($urandom_range(0, 100));
    if (roll < 20) begin
      c = hsl2rgb_in_t'($urandom);
    end else if (roll < 30) begin
      c.saturation_percent = 8'd0;
      c.lightness_percent  = 8'($urandom_range(0, 255));
    end else if (roll < 45) begin
      c.hue_degrees        = edge_hue();
      c.saturation_percent = ($urandom_range(0, 1) == 0) ? 8'd100 : 8'($urandom_range(1, 255));
      c.lightness_percent  = ($urandom_range(0, 1) == 0) ? 8'(49 + $urandom_range(0, 2))
                                                         : 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic send_color(hsl2rgb_in_t c, int gap);
    bit taken;
    in_data <= c;
    start   <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  initial begin
    hsl2rgb_in_t directed[$];
    int          sent;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, every ramp segment, clamping, grey and hue wrap
    directed = '{
      '{16'd0,     8'd100, 8'd50},  '{16'd59,    8'd100, 8'd50},
      '{16'd60,    8'd100, 8'd50},  '{16'd119,   8'd100, 8'd50},
      '{16'd120,   8'd100, 8'd50},  '{16'd179,   8'd100, 8'd50},
      '{16'd180,   8'd100, 8'd50},  '{16'd239,   8'd100, 8'd50},
      '{16'd240,   8'd100, 8'd50},  '{16'd359,   8'd100, 8'd50},
      '{16'd360,   8'd100, 8'd50},  '{16'd65535, 8'd100, 8'd50},
      '{16'd200,   8'd0,   8'd0},   '{16'd200,   8'd0,   8'd100},
      '{16'd200,   8'd0,   8'd255}, '{16'd200,   8'd0,   8'd33},
      '{16'd30,    8'd1,   8'd49},  '{16'd30,    8'd101, 8'd49},
      '{16'd30,    8'd255, 8'd50},  '{16'd300,   8'd255, 8'd255},
      '{16'd300,   8'd60,  8'd0},   '{16'd90,    8'd60,  8'd101},
      '{16'd65535, 8'd255, 8'd255}, '{16'd0,     8'd0,   8'd0}
    };
    foreach (directed[i]) begin
      send_color(directed[i], pick_gap(i < 12));
    end
    sent = directed.size();

    quiet_burst = 1'b0;
    while (sent < NumItems) begin
      if (sent % 150 == 0) begin
        quiet_burst = ($urandom_range(0, 3) == 0);
      end
      if (sent == NumItems / 2) begin
        start <= 1'b0;
        wait_drained();
      end
      send_color(random_color(), pick_gap(quiet_burst));
      sent++;
    end
    start <= 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
